// ----- src/escu_pkg.sv -----
package escu_pkg;

   // Result status codes.
   localparam logic [1:0] ST_CONTINUE = 2'd0;
   localparam logic [1:0] ST_READY    = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;
   localparam logic [1:0] ST_IDLE     = 2'd3;

   // Surrogate and code point limits.
   localparam logic [23:0] SURR_HI_LO = 24'h00D800;
   localparam logic [23:0] SURR_HI_HI = 24'h00DBFF;
   localparam logic [23:0] SURR_LO_LO = 24'h00DC00;
   localparam logic [23:0] SURR_LO_HI = 24'h00DFFF;
   localparam logic [23:0] CP_MAX     = 24'h10FFFF;
   localparam logic [20:0] ASCII_LIMIT = 21'h000080;
   localparam logic [20:0] TWO_BYTE_LIMIT = 21'h000800;
   localparam logic [20:0] THREE_BYTE_LIMIT = 21'h010000;
   localparam logic [20:0] PLANE1_BASE = 21'h010000;

   // Digit limits of the various escape forms.
   localparam logic [3:0] BRACE_MAX_DIGITS = 4'd9;
   localparam logic [3:0] BIGU_MAX_DIGITS  = 4'd6;
   localparam logic [3:0] HEX_MAX_DIGITS   = 4'd4;
   localparam logic [3:0] OCT_MAX_DIGITS   = 4'd3;
   localparam logic [23:0] OCT_TWO_DIGIT_MAX = 24'd31;

   // Phases of the second half of a surrogate pair.
   localparam logic [1:0] PHASE_SLASH  = 2'd0;
   localparam logic [1:0] PHASE_U      = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_OCTAL,
      MODE_HEX,
      MODE_BIGU,
      MODE_UCHAR,
      MODE_BRACE,
      MODE_PAIR
   } escu_mode_type;

   typedef struct packed {
      logic       first;
      logic [7:0] char_in;
   } escu_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       consumed;
      logic [2:0] out_len;
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
   } escu_rsp_type;

   typedef struct packed {
      logic [2:0] len;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
   } escu_utf8_type;

endpackage

// ----- src/escu_utf8_enc.sv -----
module escu_utf8_enc (
   input  logic [20:0]            cp,
   output escu_pkg::escu_utf8_type enc
);

   // Pick the sequence length from the code point range and split the bits.
   always_comb begin
      enc = '0;
      if (cp < escu_pkg::ASCII_LIMIT) begin
         enc.len   = 3'd1;
         enc.byte0 = {1'b0, cp[6:0]};
      end else if (cp < escu_pkg::TWO_BYTE_LIMIT) begin
         enc.len   = 3'd2;
         enc.byte0 = {3'b110, cp[10:6]};
         enc.byte1 = {2'b10, cp[5:0]};
      end else if (cp < escu_pkg::THREE_BYTE_LIMIT) begin
         enc.len   = 3'd3;
         enc.byte0 = {4'b1110, cp[15:12]};
         enc.byte1 = {2'b10, cp[11:6]};
         enc.byte2 = {2'b10, cp[5:0]};
      end else begin
         enc.len   = 3'd4;
         enc.byte0 = {5'b11110, cp[20:18]};
         enc.byte1 = {2'b10, cp[17:12]};
         enc.byte2 = {2'b10, cp[11:6]};
         enc.byte3 = {2'b10, cp[5:0]};
      end
   end

endmodule

// ----- src/escu_decode.sv -----
module escu_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  escu_pkg::escu_req_type  item,
   output escu_pkg::escu_rsp_type  result
);

   localparam logic [7:0] CHAR_LC_B   = 8'h62;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] CHAR_LC_N   = 8'h6E;
   localparam logic [7:0] CHAR_LC_R   = 8'h72;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CHAR_LC_V   = 8'h76;
   localparam logic [7:0] CHAR_LC_X   = 8'h78;
   localparam logic [7:0] CHAR_UC_X   = 8'h58;
   localparam logic [7:0] CHAR_LC_U   = 8'h75;
   localparam logic [7:0] CHAR_UC_U   = 8'h55;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_F   = 8'h46;

   escu_pkg::escu_mode_type mode_ff, mode_in;
   logic [3:0]  dcount_ff, dcount_in;
   logic [23:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [9:0]  hsur_ff, hsur_in;
   logic [1:0]  phase_ff, phase_in;

   logic [7:0]  ch;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic        oct_ok;
   logic [27:0] add_sum;
   logic [23:0] acc_add;
   logic        ovf_add;
   logic [3:0]  dcount_add;
   logic [23:0] acc_oct;
   logic [3:0]  maxd;

   logic        term_lit;
   logic        term_err;
   logic        term_fin;
   logic        term_idle;
   logic        consumed;
   logic [7:0]  lit;
   logic [23:0] fin_acc;
   logic        fin_ovf;
   logic        fin_pair;

   logic        fin_bad;
   logic [20:0] fin_cp;
   escu_pkg::escu_utf8_type enc;

   assign ch = item.char_in;

   // Hex digit value of the current character.
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = ch[3:0];
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         hex_val = ch[3:0];
      end else if ((ch >= CHAR_LC_A && ch <= CHAR_LC_F) ||
                   (ch >= CHAR_UC_A && ch <= CHAR_UC_F)) begin
         hex_val = ch[3:0] + 4'd9;
      end else begin
         hex_ok  = 1'b0;
      end
   end

   assign oct_ok = (ch >= CHAR_ZERO) && (ch <= CHAR_SEVEN);

   // Appending one hex digit or one octal digit to the run.
   assign add_sum    = {acc_ff, hex_val};
   assign acc_add    = add_sum[23:0];
   assign ovf_add    = ovf_ff || (add_sum > {4'd0, escu_pkg::CP_MAX});
   assign dcount_add = dcount_ff + 4'd1;
   assign acc_oct    = {acc_ff[20:0], 3'b000} + {21'd0, ch[2:0]};
   assign maxd       = (mode_ff == escu_pkg::MODE_BIGU) ? escu_pkg::BIGU_MAX_DIGITS
                                                        : escu_pkg::HEX_MAX_DIGITS;

   // Parser step: next state and the kind of result this character gives.
   always_comb begin
      mode_in   = mode_ff;
      dcount_in = dcount_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      hsur_in   = hsur_ff;
      phase_in  = phase_ff;
      term_lit  = 1'b0;
      term_err  = 1'b0;
      term_fin  = 1'b0;
      term_idle = 1'b0;
      consumed  = 1'b1;
      lit       = ch;
      fin_acc   = acc_ff;
      fin_ovf   = ovf_ff;
      fin_pair  = 1'b0;

      if (item.first) begin
         mode_in   = escu_pkg::MODE_IDLE;
         dcount_in = 4'd0;
         acc_in    = 24'd0;
         ovf_in    = 1'b0;
         hsur_in   = 10'd0;
         phase_in  = escu_pkg::PHASE_SLASH;
         case (ch)
            CHAR_LC_B: begin lit = 8'h08; term_lit = 1'b1; end
            CHAR_LC_F: begin lit = 8'h0C; term_lit = 1'b1; end
            CHAR_LC_N: begin lit = 8'h0A; term_lit = 1'b1; end
            CHAR_LC_R: begin lit = 8'h0D; term_lit = 1'b1; end
            CHAR_LC_T: begin lit = 8'h09; term_lit = 1'b1; end
            CHAR_LC_V: begin lit = 8'h0B; term_lit = 1'b1; end
            CHAR_LC_X, CHAR_UC_X: mode_in = escu_pkg::MODE_HEX;
            CHAR_UC_U: mode_in = escu_pkg::MODE_BIGU;
            CHAR_LC_U: mode_in = escu_pkg::MODE_UCHAR;
            default: begin
               if (oct_ok) begin
                  mode_in   = escu_pkg::MODE_OCTAL;
                  acc_in    = {21'd0, ch[2:0]};
                  dcount_in = 4'd1;
               end else begin
                  term_lit = 1'b1;
               end
            end
         endcase
      end else begin
         case (mode_ff)
            escu_pkg::MODE_OCTAL: begin
               if (oct_ok) begin
                  acc_in    = acc_oct;
                  dcount_in = dcount_add;
                  if (dcount_add >= escu_pkg::OCT_MAX_DIGITS ||
                      acc_oct > escu_pkg::OCT_TWO_DIGIT_MAX) begin
                     term_fin = 1'b1;
                     fin_acc  = acc_oct;
                  end
               end else begin
                  term_fin = 1'b1;
                  consumed = 1'b0;
               end
            end
            escu_pkg::MODE_HEX, escu_pkg::MODE_BIGU, escu_pkg::MODE_UCHAR: begin
               if (mode_ff == escu_pkg::MODE_UCHAR && dcount_ff == 4'd0 &&
                   ch == CHAR_LBRACE) begin
                  mode_in = escu_pkg::MODE_BRACE;
               end else if (!hex_ok) begin
                  consumed = 1'b0;
                  if (dcount_ff == 4'd0) begin
                     term_err = 1'b1;
                  end else begin
                     term_fin = 1'b1;
                  end
               end else begin
                  acc_in    = acc_add;
                  dcount_in = dcount_add;
                  ovf_in    = ovf_add;
                  if (dcount_add >= maxd) begin
                     if (mode_ff == escu_pkg::MODE_UCHAR && acc_add >= escu_pkg::SURR_HI_LO &&
                         acc_add <= escu_pkg::SURR_HI_HI) begin
                        // High surrogate: wait for the second escape.
                        mode_in   = escu_pkg::MODE_PAIR;
                        phase_in  = escu_pkg::PHASE_SLASH;
                        hsur_in   = acc_add[9:0];
                        acc_in    = 24'd0;
                        dcount_in = 4'd0;
                        ovf_in    = 1'b0;
                     end else begin
                        term_fin = 1'b1;
                        fin_acc  = acc_add;
                        fin_ovf  = ovf_add;
                     end
                  end
               end
            end
            escu_pkg::MODE_BRACE: begin
               if (ch == CHAR_RBRACE) begin
                  if (dcount_ff == 4'd0) begin
                     term_err = 1'b1;
                  end else begin
                     term_fin = 1'b1;
                  end
               end else if (dcount_ff >= escu_pkg::BRACE_MAX_DIGITS || !hex_ok) begin
                  term_err = 1'b1;
                  consumed = 1'b0;
               end else begin
                  acc_in    = acc_add;
                  dcount_in = dcount_add;
                  ovf_in    = ovf_add;
               end
            end
            escu_pkg::MODE_PAIR: begin
               if (phase_ff == escu_pkg::PHASE_SLASH) begin
                  if (ch == CHAR_BSLASH) begin
                     phase_in = escu_pkg::PHASE_U;
                  end else begin
                     term_err = 1'b1;
                     consumed = 1'b0;
                  end
               end else if (phase_ff == escu_pkg::PHASE_U) begin
                  if (ch == CHAR_LC_U || ch == CHAR_UC_U) begin
                     phase_in = escu_pkg::PHASE_DIGITS;
                  end else begin
                     term_err = 1'b1;
                     consumed = 1'b0;
                  end
               end else if (!hex_ok) begin
                  consumed = 1'b0;
                  if (dcount_ff == 4'd0) begin
                     term_err = 1'b1;
                  end else begin
                     term_fin = 1'b1;
                     fin_pair = 1'b1;
                  end
               end else begin
                  acc_in    = acc_add;
                  dcount_in = dcount_add;
                  ovf_in    = ovf_add;
                  if (dcount_add >= escu_pkg::HEX_MAX_DIGITS) begin
                     term_fin = 1'b1;
                     fin_pair = 1'b1;
                     fin_acc  = acc_add;
                     fin_ovf  = ovf_add;
                  end
               end
            end
            default: begin
               term_idle = 1'b1;
               consumed  = 1'b0;
            end
         endcase
      end

      // Any finished sequence leaves the parser idle.
      if (term_lit || term_err || term_fin || term_idle) begin
         mode_in   = escu_pkg::MODE_IDLE;
         dcount_in = 4'd0;
         acc_in    = 24'd0;
         ovf_in    = 1'b0;
         hsur_in   = 10'd0;
         phase_in  = escu_pkg::PHASE_SLASH;
      end
   end

   // Range check of the final value and the code point to encode.
   always_comb begin
      if (fin_pair) begin
         fin_bad = fin_ovf || (fin_acc < escu_pkg::SURR_LO_LO) ||
                   (fin_acc > escu_pkg::SURR_LO_HI);
         fin_cp  = escu_pkg::PLANE1_BASE + {1'b0, hsur_ff, fin_acc[9:0]};
      end else begin
         fin_bad = fin_ovf || (fin_acc > escu_pkg::CP_MAX) ||
                   (fin_acc >= escu_pkg::SURR_HI_LO && fin_acc <= escu_pkg::SURR_LO_HI);
         fin_cp  = fin_acc[20:0];
      end
   end

   escu_utf8_enc u_enc (
      .cp  (fin_cp),
      .enc (enc)
   );

   // Assemble the result item.
   always_comb begin
      result          = '0;
      result.status   = escu_pkg::ST_CONTINUE;
      result.consumed = consumed;
      if (term_lit) begin
         result.status    = escu_pkg::ST_READY;
         result.out_len   = 3'd1;
         result.out_byte0 = lit;
      end else if (term_err || (term_fin && fin_bad)) begin
         result.status = escu_pkg::ST_ERROR;
      end else if (term_fin) begin
         result.status    = escu_pkg::ST_READY;
         result.out_len   = enc.len;
         result.out_byte0 = enc.byte0;
         result.out_byte1 = enc.byte1;
         result.out_byte2 = enc.byte2;
         result.out_byte3 = enc.byte3;
      end else if (term_idle) begin
         result.status = escu_pkg::ST_IDLE;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= escu_pkg::MODE_IDLE;
         dcount_ff <= 4'd0;
         acc_ff    <= 24'd0;
         ovf_ff    <= 1'b0;
         hsur_ff   <= 10'd0;
         phase_ff  <= escu_pkg::PHASE_SLASH;
      end else if (fire) begin
         mode_ff   <= mode_in;
         dcount_ff <= dcount_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         hsur_ff   <= hsur_in;
         phase_ff  <= phase_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_len: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == escu_pkg::ST_READY |-> result.out_len != 3'd0 &&
      result.out_len <= 3'd4)
      else $error("ready result with bad byte count");

   a_not_ready_empty: assert property (@(posedge clock) disable iff (reset)
      fire && result.status != escu_pkg::ST_READY |-> result.out_len == 3'd0 &&
      result.out_byte0 == 8'd0 && result.out_byte3 == 8'd0)
      else $error("bytes reported on a result that is not ready");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && result.status != escu_pkg::ST_CONTINUE |=> mode_ff == escu_pkg::MODE_IDLE &&
      dcount_ff == 4'd0 && acc_ff == 24'd0)
      else $error("parser not cleared after a finished sequence");

   a_first_consumed: assert property (@(posedge clock) disable iff (reset)
      fire && item.first |-> result.consumed &&
      (result.status == escu_pkg::ST_READY || result.status == escu_pkg::ST_CONTINUE))
      else $error("opening character not taken");

   a_pair_phase: assert property (@(posedge clock) disable iff (reset)
      mode_ff != escu_pkg::MODE_PAIR |-> phase_ff == escu_pkg::PHASE_SLASH)
      else $error("pair phase set outside a surrogate pair");
`endif

endmodule

// ----- src/escape_sequence_to_utf8.sv -----
// Escape sequence decoder: one character per request, one result per request.
// Each accepted request is held in the input register, and its result is registered in the result register.
// Throughput: one request per cycle unless rsp_stall holds a full result register; one parser pass per character.
// rsp_stall holds the result register and backs up into the input register only when both are full.
// Reset (synchronous, active high) empties both registers and returns the parser to idle.
module escape_sequence_to_utf8 (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  escu_pkg::escu_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output escu_pkg::escu_rsp_type rsp_data
);

   logic                   in_valid_ff, in_valid_in;
   escu_pkg::escu_req_type in_data_ff;
   logic                   out_valid_ff, out_valid_in;
   escu_pkg::escu_rsp_type out_data_ff;

   logic                   advance;
   logic                   accept;
   escu_pkg::escu_rsp_type step_result;

   // The held request moves on whenever the result register is free or being taken.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   escu_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .result (step_result)
   );

   // Occupancy of the input and result registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
